// File: design/dww_pkg.sv
// Shared types and constants for the detab and word wrap block.
// Used by every module of the block but dww_ram; depends on nothing else.
package dww_pkg;

   // Character codes that steer the folding logic.
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   // Configuration register widths, reset values and indexes.
   localparam int          LINE_W_BITS      = 6;
   localparam int          TAB_W_BITS       = 4;
   localparam logic [5:0]  LINE_WIDTH_RESET = 6'd40;
   localparam logic [3:0]  TAB_WIDTH_RESET  = 4'd4;
   localparam logic [0:0]  CSR_LINE_WIDTH   = 1'b0;
   localparam logic [0:0]  CSR_TAB_WIDTH    = 1'b1;

   // Sizes of the design.
   localparam int HOLD_DEPTH_DEFAULT  = 64;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int MAX_RESULTS         = 64;
   localparam int RES_CNT_W           = $clog2(MAX_RESULTS + 1);
   localparam int COL_W               = 7;

   // One character operation passed from the front end to the back end.
   typedef enum logic [0:0] {
      OP_NOP,
      OP_CHAR
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  ch;
      logic        last;   // last operation produced by this input transaction
      logic        eot;    // the input transaction carried the end of text flag
   } op_type;

   // Back end sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_HELD_RD,
      ST_HELD_OUT,
      ST_HELD_RET,
      ST_NEWLINE,
      ST_PUT,
      ST_OUT_CHAR,
      ST_OP_DONE,
      ST_FINISH
   } back_state_type;

   // Where the sequencer continues after the held characters are sent.
   typedef enum logic [2:0] {
      RET_NEWLINE,
      RET_SPACE,
      RET_FOLD,
      RET_FULL,
      RET_EOT
   } held_ret_type;

endpackage

// File: design/detab_and_word_wrap.sv
// Top level of the detab and word wrap block: configuration registers,
// front end, operation queue and back end. Depends on dww_pkg and submodules.
//
//   Channel   Direction  Handshake         Payload
//   req_      in         valid / ready     in_char, end_of_text
//   rsp_      out        valid / ready     out_char, run_last
//   csr_      in         write enable      index (0 line width, 1 tab width)
//
// The back end sets the rate: it takes a new operation from the queue only when it is
// through with the last one. Every held character sent out first waits for a registered
// hold RAM read, and a fold or hard break adds a newline, then sends the held characters
// that move down. Reset is synchronous and needs no clearing pass. A stalled rsp_ channel
// stops the back end only; input keeps being taken until the queue fills.
module detab_and_word_wrap
   import dww_pkg::*;
#(
   parameter int HOLD_DEPTH  = HOLD_DEPTH_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_in_char,
   input  logic                   req_end_of_text,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_char,
   output logic                   rsp_run_last,
   input  logic                   csr_we,
   input  logic [0:0]             csr_index,
   input  logic [LINE_W_BITS-1:0] csr_wdata
);

   logic [LINE_W_BITS-1:0] line_width_ff, line_width_in;
   logic [TAB_W_BITS-1:0]  tab_width_ff, tab_width_in;
   logic                   push_valid;
   logic                   push_ready;
   op_type                 push_op;
   logic                   pop_valid;
   logic                   pop_ready;
   op_type                 pop_op;

   // Configuration register writes.
   always_comb begin
      line_width_in = line_width_ff;
      tab_width_in  = tab_width_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LINE_WIDTH: line_width_in = csr_wdata;
            CSR_TAB_WIDTH:  tab_width_in  = csr_wdata[TAB_W_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         tab_width_ff  <= TAB_WIDTH_RESET;
      end else begin
         line_width_ff <= line_width_in;
         tab_width_ff  <= tab_width_in;
      end
   end

   dww_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_char     (req_in_char),
      .req_end_of_text (req_end_of_text),
      .tab_width       (tab_width_ff),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_op         (push_op)
   );

   dww_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   dww_back #(
      .HOLD_DEPTH (HOLD_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .line_width   (line_width_ff),
      .q_valid      (pop_valid),
      .q_ready      (pop_ready),
      .q_op         (pop_op),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_run_last (rsp_run_last)
   );

endmodule

// File: design/dww_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Stands alone; used for the held line tail of the word wrap block.
module dww_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/dww_fifo.sv
// Short operation queue between the front end and the back end.
// Depends on dww_pkg for the operation type.
module dww_fifo
   import dww_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   push_valid,
   output logic   push_ready,
   input  op_type push_op,
   output logic   pop_valid,
   input  logic   pop_ready,
   output op_type pop_op
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   op_type        slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push_fire;
   logic          pop_fire;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Pointer and fill level updates, with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage; no reset needed for payload.
   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// File: design/dww_front.sv
// Front end: accepts input transactions and turns each byte into character
// operations, expanding a tab into spaces. Depends on dww_pkg.
module dww_front
   import dww_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_in_char,
   input  logic                  req_end_of_text,
   input  logic [TAB_W_BITS-1:0] tab_width,
   output logic                  push_valid,
   input  logic                  push_ready,
   output op_type                push_op
);

   logic                  busy_ff, busy_in;
   logic [7:0]            ch_ff, ch_in;
   logic                  eot_ff, eot_in;
   logic [TAB_W_BITS-1:0] rem_ff, rem_in;
   logic                  is_tab;
   logic                  push_fire;
   logic                  done_fire;
   logic                  req_fire;

   assign is_tab = (ch_ff == CH_TAB);

   // Build the operation for the current byte or the current tab space.
   always_comb begin
      push_op.eot = eot_ff;
      if (is_tab) begin
         push_op.kind = (rem_ff == '0) ? OP_NOP : OP_CHAR;
         push_op.ch   = CH_SPACE;
         push_op.last = (rem_ff <= TAB_W_BITS'(1));
      end else begin
         push_op.kind = OP_CHAR;
         push_op.ch   = ch_ff;
         push_op.last = 1'b1;
      end
   end

   assign push_valid = busy_ff;
   assign push_fire  = busy_ff && push_ready;
   assign done_fire  = push_fire && push_op.last;
   assign req_ready  = !busy_ff || done_fire;
   assign req_fire   = req_valid && req_ready;

   // Latch a new byte, or count down the spaces of a tab.
   always_comb begin
      busy_in = busy_ff;
      ch_in   = ch_ff;
      eot_in  = eot_ff;
      rem_in  = rem_ff;
      if (req_fire) begin
         busy_in = 1'b1;
         ch_in   = req_in_char;
         eot_in  = req_end_of_text;
         rem_in  = tab_width;
      end else if (done_fire) begin
         busy_in = 1'b0;
      end else if (push_fire) begin
         rem_in = rem_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff  <= ch_in;
      eot_ff <= eot_in;
      rem_ff <= rem_in;
   end

endmodule

// File: design/dww_back.sv
// Back end: folds the character operations into lines, holding the last
// space and the word after it in a RAM. Depends on dww_pkg and dww_ram.
module dww_back
   import dww_pkg::*;
#(
   parameter int HOLD_DEPTH = HOLD_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [LINE_W_BITS-1:0] line_width,
   input  logic                   q_valid,
   output logic                   q_ready,
   input  op_type                 q_op,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_char,
   output logic                   rsp_run_last
);

   localparam int AW = $clog2(HOLD_DEPTH);
   localparam int CW = $clog2(HOLD_DEPTH + 1);

   back_state_type        state_ff, state_in;
   op_type                op_ff, op_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         ptr_ff, ptr_in;
   held_ret_type          ret_ff, ret_in;
   logic                  nl_fold_ff, nl_fold_in;
   logic [RES_CNT_W-1:0]  res_cnt_ff, res_cnt_in;
   logic                  pend_v_ff, pend_v_in;
   logic [7:0]            pend_ch_ff, pend_ch_in;
   logic                  out_v_ff, out_v_in;
   logic [7:0]            out_ch_ff, out_ch_in;
   logic                  out_last_ff, out_last_in;

   logic [LINE_W_BITS-1:0] w_eff;
   logic                   at_limit;
   logic                   is_nl;
   logic                   is_sp;
   logic                   emit_req;
   logic [7:0]             emit_ch;
   logic                   res_full;
   logic                   out_free;
   logic                   can_take;
   logic                   emit_go;
   logic                   push_store;
   logic                   fin_go;
   logic                   held_more;
   logic [CW-1:0]          cnt_m1;

   logic                   ram_we;
   logic [AW-1:0]          ram_wa;
   logic [7:0]             ram_wd;
   logic                   ram_re;
   logic [AW-1:0]          ram_ra;
   logic [7:0]             ram_rd;

   dww_ram #(
      .WIDTH (8),
      .DEPTH (HOLD_DEPTH)
   ) u_hold (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // Line limit and character class of the current operation.
   assign w_eff     = (line_width == '0) ? LINE_W_BITS'(1) : line_width;
   assign at_limit  = (col_ff >= COL_W'(w_eff));
   assign is_nl     = (op_ff.ch == CH_NEWLINE);
   assign is_sp     = (op_ff.ch == CH_SPACE);
   assign held_more = ((ptr_ff + 1'b1) < cnt_ff);
   assign cnt_m1    = cnt_ff - 1'b1;

   // Emission request of the sequencer and whether the sink takes it.
   // Past the per-transaction result limit a character is dropped.
   assign emit_req   = (state_ff == ST_HELD_OUT) || (state_ff == ST_NEWLINE) ||
                       (state_ff == ST_OUT_CHAR);
   assign emit_ch    = (state_ff == ST_HELD_OUT) ? ram_rd :
                       (state_ff == ST_NEWLINE)  ? CH_NEWLINE : op_ff.ch;
   assign res_full   = (res_cnt_ff == RES_CNT_W'(MAX_RESULTS));
   assign out_free   = !out_v_ff || rsp_ready;
   assign can_take   = !pend_v_ff || out_free;
   assign emit_go    = emit_req && (res_full || can_take);
   assign push_store = emit_req && !res_full && can_take;
   assign fin_go     = (state_ff == ST_FINISH) && (!pend_v_ff || out_free);

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (op_ff.kind == OP_NOP) begin
               state_in = ST_OP_DONE;
            end else if (is_nl || is_sp) begin
               state_in = (cnt_ff != '0) ? ST_HELD_RD : ST_HELD_RET;
            end else begin
               state_in = at_limit ? ST_NEWLINE : ST_PUT;
            end
         end
         ST_HELD_RD: begin
            state_in = ST_HELD_OUT;
         end
         ST_HELD_OUT: begin
            if (emit_go) begin
               state_in = held_more ? ST_HELD_RD : ST_HELD_RET;
            end
         end
         ST_HELD_RET: begin
            unique case (ret_ff)
               RET_NEWLINE: state_in = ST_NEWLINE;
               RET_SPACE:   state_in = at_limit ? ST_NEWLINE : ST_OP_DONE;
               RET_FOLD:    state_in = ST_PUT;
               RET_FULL:    state_in = ST_OUT_CHAR;
               RET_EOT:     state_in = ST_FINISH;
               default:     state_in = ST_FINISH;
            endcase
         end
         ST_NEWLINE: begin
            if (emit_go) begin
               if (!nl_fold_ff) begin
                  state_in = ST_OP_DONE;
               end else begin
                  state_in = (cnt_ff > CW'(1)) ? ST_HELD_RD : ST_PUT;
               end
            end
         end
         ST_PUT: begin
            if (cnt_ff == '0) begin
               state_in = ST_OUT_CHAR;
            end else if (cnt_ff >= CW'(HOLD_DEPTH)) begin
               state_in = ST_HELD_RD;
            end else begin
               state_in = ST_OP_DONE;
            end
         end
         ST_OUT_CHAR: begin
            if (emit_go) begin
               state_in = ST_OP_DONE;
            end
         end
         ST_OP_DONE: begin
            if (!op_ff.last) begin
               state_in = ST_IDLE;
            end else if (op_ff.eot) begin
               state_in = (cnt_ff != '0) ? ST_HELD_RD : ST_HELD_RET;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (fin_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: queue pop, hold RAM access, column and hold count.
   always_comb begin
      op_in      = op_ff;
      col_in     = col_ff;
      cnt_in     = cnt_ff;
      ptr_in     = ptr_ff;
      ret_in     = ret_ff;
      nl_fold_in = nl_fold_ff;
      q_ready    = 1'b0;
      ram_we     = 1'b0;
      ram_wa     = '0;
      ram_wd     = '0;
      ram_re     = 1'b0;
      ram_ra     = ptr_ff[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               op_in = q_op;
            end
         end
         ST_DECODE: begin
            // A newline or a space first sends every held character.
            ptr_in     = '0;
            nl_fold_in = 1'b1;
            if (is_nl) begin
               ret_in = RET_NEWLINE;
            end else if (is_sp) begin
               ret_in = RET_SPACE;
            end
         end
         ST_HELD_RD: begin
            ram_re = 1'b1;
         end
         ST_HELD_OUT: begin
            if (emit_go) begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_HELD_RET: begin
            cnt_in     = '0;
            nl_fold_in = 1'b0;
            unique case (ret_ff)
               RET_SPACE: begin
                  // Below the limit the space opens a new held tail.
                  if (!at_limit) begin
                     ram_we = 1'b1;
                     ram_wa = '0;
                     ram_wd = CH_SPACE;
                     cnt_in = CW'(1);
                     col_in = col_ff + 1'b1;
                  end
               end
               RET_EOT: begin
                  col_in = '0;
               end
               RET_NEWLINE, RET_FOLD, RET_FULL: begin
               end
               default: begin
               end
            endcase
         end
         ST_NEWLINE: begin
            if (emit_go) begin
               if (!nl_fold_ff) begin
                  col_in = '0;
               end else begin
                  // Fold: the word after the held space moves down a line.
                  col_in = (cnt_ff != '0) ? COL_W'(cnt_m1) : '0;
                  if (cnt_ff > CW'(1)) begin
                     ptr_in = CW'(1);
                     ret_in = RET_FOLD;
                  end else begin
                     cnt_in = '0;
                  end
               end
            end
         end
         ST_PUT: begin
            if (cnt_ff != '0) begin
               if (cnt_ff >= CW'(HOLD_DEPTH)) begin
                  // Hold store full: send the tail unchanged, then the byte.
                  ptr_in = '0;
                  ret_in = RET_FULL;
               end else begin
                  ram_we = 1'b1;
                  ram_wa = cnt_ff[AW-1:0];
                  ram_wd = op_ff.ch;
                  cnt_in = cnt_ff + 1'b1;
                  col_in = col_ff + 1'b1;
               end
            end
         end
         ST_OUT_CHAR: begin
            if (emit_go) begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_OP_DONE: begin
            ptr_in = '0;
            ret_in = RET_EOT;
         end
         ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // Result sink: one pending character, so the last one can be marked.
   always_comb begin
      pend_v_in   = pend_v_ff;
      pend_ch_in  = pend_ch_ff;
      out_v_in    = out_v_ff;
      out_ch_in   = out_ch_ff;
      out_last_in = out_last_ff;
      res_cnt_in  = res_cnt_ff;
      if (out_v_ff && rsp_ready) begin
         out_v_in = 1'b0;
      end
      if (push_store) begin
         res_cnt_in = res_cnt_ff + 1'b1;
         pend_v_in  = 1'b1;
         pend_ch_in = emit_ch;
         if (pend_v_ff) begin
            out_v_in    = 1'b1;
            out_ch_in   = pend_ch_ff;
            out_last_in = 1'b0;
         end
      end else if (fin_go) begin
         res_cnt_in = '0;
         pend_v_in  = 1'b0;
         if (pend_v_ff) begin
            out_v_in    = 1'b1;
            out_ch_in   = pend_ch_ff;
            out_last_in = 1'b1;
         end
      end
   end

   assign rsp_valid    = out_v_ff;
   assign rsp_out_char = out_ch_ff;
   assign rsp_run_last = out_last_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         col_ff     <= '0;
         cnt_ff     <= '0;
         nl_fold_ff <= 1'b0;
         res_cnt_ff <= '0;
         pend_v_ff  <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         col_ff     <= col_in;
         cnt_ff     <= cnt_in;
         nl_fold_ff <= nl_fold_in;
         res_cnt_ff <= res_cnt_in;
         pend_v_ff  <= pend_v_in;
         out_v_ff   <= out_v_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ptr_ff      <= ptr_in;
      ret_ff      <= ret_in;
      pend_ch_ff  <= pend_ch_in;
      out_ch_ff   <= out_ch_in;
      out_last_ff <= out_last_in;
   end

endmodule
